// ===== design/marker_length_prefixed_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the marker length prefixed extractor
// Immediate-cycle and next-cycle implication checks, reset aware.
// ----------------------------------------------------------------------------
`ifndef MARKER_LENGTH_PREFIXED_EXTRACTOR_ASSERT_SVH
`define MARKER_LENGTH_PREFIXED_EXTRACTOR_ASSERT_SVH

// cons must hold in the same cycle as ante
`define MLPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlpe: implication check failed");

// cons must hold in the cycle after ante
`define MLPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlpe: next-cycle check failed");

`endif

// ===== design/mlpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpe_pkg
// Shared types and constants of the marker length prefixed extractor.
// ----------------------------------------------------------------------------
package mlpe_pkg;

    localparam int MARKER_MAX_DEF        = 8;
    localparam int MAX_LENGTH_DIGITS_DEF = 4;

    localparam int MARKER_W   = 64;
    localparam int MLEN_W     = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int LEN_W      = 14;

    localparam logic [MARKER_W-1:0] MARKER_RESET = 64'd18691914353241922;
    localparam logic [MLEN_W-1:0]   MLEN_RESET   = 4'd7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARKER_BYTES  = 1'b0,
        CFG_MARKER_LENGTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_PASS    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

endpackage

// ===== design/mlpe_in_if.sv =====
// ----------------------------------------------------------------------------
// mlpe_in_if
// Input byte channel: mode and data byte with valid/ready.
// ----------------------------------------------------------------------------
interface mlpe_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// ===== design/mlpe_out_if.sv =====
// ----------------------------------------------------------------------------
// mlpe_out_if
// Result channel: kind, byte and last flag with valid/ready.
// ----------------------------------------------------------------------------
interface mlpe_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// ===== design/mlpe_cell.sv =====
// ----------------------------------------------------------------------------
// mlpe_cell
// One window cell: holds a byte, takes its neighbor's byte on a shift and
// compares the incoming byte against its marker byte.
// ----------------------------------------------------------------------------
module mlpe_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_want,
    output logic [7:0] o_byte,
    output logic [7:0] o_next,
    output logic       o_match
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    assign n_byte  = i_shift ? i_byte : r_byte;
    assign o_byte  = r_byte;
    assign o_next  = n_byte;
    assign o_match = (i_byte == i_want);

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

// ===== design/mlpe_phase.sv =====
// ----------------------------------------------------------------------------
// mlpe_phase
// Framing state: decimal length parse and payload count after a marker hit.
// ----------------------------------------------------------------------------
`include "marker_length_prefixed_extractor_assert.svh"

module mlpe_phase #(
    parameter int MAX_LENGTH_DIGITS = mlpe_pkg::MAX_LENGTH_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_req,
    input  logic [7:0]        i_data,
    input  logic              i_hit,
    output logic              o_search,
    output mlpe_pkg::t_result o_res
);

    localparam int DIG_W = $clog2(MAX_LENGTH_DIGITS + 1);
    localparam int LEN_W = mlpe_pkg::LEN_W;

    mlpe_pkg::t_phase r_phase, n_phase;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [DIG_W-1:0] r_cnt, n_cnt;

    logic             s_digit;
    logic [7:0]       s_dval;

    assign s_dval   = i_data - mlpe_pkg::CH_ZERO;
    assign s_digit  = (i_data >= mlpe_pkg::CH_ZERO) && (i_data <= mlpe_pkg::CH_NINE);
    assign o_search = (r_phase != mlpe_pkg::PH_LENGTH) && (r_phase != mlpe_pkg::PH_PAYLOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mlpe_pkg::PH_SEARCH;
            r_acc   <= '0;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        o_res   = '0;
        unique case (r_phase)
            mlpe_pkg::PH_LENGTH: begin
                if (i_byte_req) begin
                    if (i_data == mlpe_pkg::CH_SPACE) begin
                        if (r_acc == '0) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = mlpe_pkg::KIND_EMPTY;
                            n_phase     = mlpe_pkg::PH_SEARCH;
                        end else begin
                            n_rem   = r_acc;
                            n_phase = mlpe_pkg::PH_PAYLOAD;
                        end
                        n_acc = '0;
                        n_cnt = '0;
                    end else if (s_digit && (r_cnt < DIG_W'(MAX_LENGTH_DIGITS))) begin
                        // acc * 10 as acc * 8 + acc * 2, wraps at LEN_W bits
                        n_acc = {r_acc[LEN_W-4:0], 3'b000} + {r_acc[LEN_W-2:0], 1'b0}
                              + {{(LEN_W-4){1'b0}}, s_dval[3:0]};
                        n_cnt = r_cnt + DIG_W'(1);
                    end else begin
                        o_res.valid = 1'b1;
                        o_res.kind  = mlpe_pkg::KIND_ERROR;
                        n_phase     = mlpe_pkg::PH_SEARCH;
                        n_acc       = '0;
                        n_cnt       = '0;
                    end
                end
            end
            mlpe_pkg::PH_PAYLOAD: begin
                if (i_byte_req) begin
                    if (r_rem != '0) begin
                        n_rem = r_rem - LEN_W'(1);
                    end
                    o_res.valid = 1'b1;
                    o_res.kind  = mlpe_pkg::KIND_PAYLOAD;
                    o_res.data  = i_data;
                    o_res.last  = (n_rem == '0);
                    if (n_rem == '0) begin
                        n_phase = mlpe_pkg::PH_SEARCH;
                    end
                end
            end
            default: begin
                // search, and the unused code behaves the same
                if (i_hit) begin
                    n_phase = mlpe_pkg::PH_LENGTH;
                    n_acc   = '0;
                    n_cnt   = '0;
                end
            end
        endcase
    end

    `MLPE_ASSERT_IMP(a_rem_nonzero, i_clk, i_rst_n, r_phase == mlpe_pkg::PH_PAYLOAD, r_rem != '0)
    `MLPE_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= DIG_W'(MAX_LENGTH_DIGITS))
    `MLPE_ASSERT_IMP(a_acc_idle, i_clk, i_rst_n, r_phase != mlpe_pkg::PH_LENGTH, r_acc == '0)

endmodule

// ===== design/marker_length_prefixed_extractor.sv =====
// ----------------------------------------------------------------------------
// marker_length_prefixed_extractor
// Byte stream input on i_in (mode 0 data, mode 1 flush), results on o_out.
// Search bytes pass through a row of window cells, newest in cell 0, and
// leave as passthrough once older than the marker window. A marker hit
// drops the marker and starts a decimal length ended by a space; that many
// bytes then come out as payload, the last one flagged.
// Results are registered: each one leaves on o_out from the output register.
// Throughput: one byte per cycle while each byte causes at most one result
// and o_out is not stalled; a byte causing n results (up to MARKER_MAX)
// keeps i_in.ready low while they drain, one per cycle through the single output register.
// Reset: window empty, search phase, marker registers at their defaults.
// A stalled receiver holds o_out; requests that cause no result are still
// taken, and the first one that causes a result is taken with its result held, then ready drops.
// Config writes on i_cfg_* take effect at once; write only while idle.
// ----------------------------------------------------------------------------
`include "marker_length_prefixed_extractor_assert.svh"

module marker_length_prefixed_extractor #(
    parameter int MARKER_MAX        = mlpe_pkg::MARKER_MAX_DEF,
    parameter int MAX_LENGTH_DIGITS = mlpe_pkg::MAX_LENGTH_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mlpe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mlpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mlpe_in_if.sink                         i_in,
    mlpe_out_if.source                      o_out
);

    localparam int CNT_W = $clog2(MARKER_MAX + 1);
    localparam int IDX_W = (MARKER_MAX > 1) ? $clog2(MARKER_MAX) : 1;

    logic [mlpe_pkg::MARKER_W-1:0] r_marker;
    logic [mlpe_pkg::MLEN_W-1:0]   r_mlen;

    logic [CNT_W-1:0]  r_fill, n_fill, v_fill;
    logic [CNT_W-1:0]  r_drain, n_drain, v_drain;
    logic              r_clr, n_clr, v_clr;
    logic              r_flush, n_flush, v_flush;
    mlpe_pkg::t_result r_sp, n_sp, v_sp;

    logic              r_out_valid;
    mlpe_pkg::t_kind   r_out_kind;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    mlpe_pkg::t_result s_emit;

    logic [7:0]            s_cell_q [MARKER_MAX];
    logic [7:0]            s_cell_n [MARKER_MAX];
    logic [MARKER_MAX-1:0] s_match;

    logic              s_acc, s_data, s_flush, s_shift, s_search, s_free;
    logic              s_hit_all, s_hit;
    logic [CNT_W-1:0]  s_len, s_c;
    mlpe_pkg::t_result s_ph_res;
    logic              s_byte_kind;

    assign s_acc    = i_in.valid && i_in.ready;
    assign s_data   = s_acc && !i_in.mode;
    assign s_flush  = s_acc && i_in.mode;
    assign s_shift  = s_data && s_search;
    assign s_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_drain == '0) && !r_sp.valid;

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out_kind;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    assign s_byte_kind = (o_out.kind == mlpe_pkg::KIND_PASS)
                      || (o_out.kind == mlpe_pkg::KIND_PAYLOAD);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= mlpe_pkg::MARKER_RESET;
            r_mlen   <= mlpe_pkg::MLEN_RESET;
        end else if (i_cfg_we) begin
            unique case (mlpe_pkg::t_cfg_idx'(i_cfg_idx))
                mlpe_pkg::CFG_MARKER_BYTES:  r_marker <= i_cfg_data;
                mlpe_pkg::CFG_MARKER_LENGTH: r_mlen   <= i_cfg_data[mlpe_pkg::MLEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (r_mlen == '0) begin
            s_len = CNT_W'(1);
        end else if (r_mlen > MARKER_MAX) begin
            s_len = CNT_W'(MARKER_MAX);
        end else begin
            s_len = CNT_W'(r_mlen);
        end
    end

    // window cell row, cell 0 newest
    for (genvar g = 0; g < MARKER_MAX; g++) begin : g_cell
        mlpe_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (s_shift),
            .i_byte  ((g == 0) ? i_in.data_byte : s_cell_q[(g == 0) ? 0 : g - 1]),
            .i_want  (r_marker[8*g +: 8]),
            .o_byte  (s_cell_q[g]),
            .o_next  (s_cell_n[g]),
            .o_match (s_match[g])
        );
    end

    assign s_c = r_fill + CNT_W'(1);

    always_comb begin
        s_hit_all = 1'b1;
        for (int i = 0; i < MARKER_MAX; i++) begin
            if ((CNT_W'(i) < s_len) && !s_match[i]) begin
                s_hit_all = 1'b0;
            end
        end
        s_hit = s_hit_all && (s_c >= s_len);
    end

    mlpe_phase #(
        .MAX_LENGTH_DIGITS (MAX_LENGTH_DIGITS)
    ) u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_req (s_data),
        .i_data     (i_in.data_byte),
        .i_hit      (s_shift && s_hit),
        .o_search   (s_search),
        .o_res      (s_ph_res)
    );

    // view of the work after this cycle's request
    always_comb begin
        v_fill  = r_fill;
        v_drain = r_drain;
        v_clr   = r_clr;
        v_flush = r_flush;
        v_sp    = r_sp;
        if (s_shift) begin
            v_fill  = s_c;
            v_flush = 1'b0;
            if (s_hit) begin
                // older bytes go out, then the marker bytes are discarded
                v_drain = s_c - s_len;
                v_clr   = 1'b1;
            end else begin
                v_drain = (s_c >= s_len) ? (s_c - s_len + CNT_W'(1)) : '0;
                v_clr   = 1'b0;
            end
        end else if (s_flush && s_search && (r_fill != '0)) begin
            v_drain = r_fill;
            v_clr   = 1'b1;
            v_flush = 1'b1;
        end else if (s_data) begin
            v_sp = s_ph_res;
        end
    end

    // one result per cycle into the output register while it is free
    always_comb begin
        n_fill  = v_fill;
        n_drain = v_drain;
        n_clr   = v_clr;
        n_flush = v_flush;
        n_sp    = v_sp;
        s_emit  = '0;
        if (s_free) begin
            if (v_sp.valid) begin
                s_emit     = v_sp;
                n_sp.valid = 1'b0;
            end else if (v_drain != '0) begin
                s_emit.valid = 1'b1;
                s_emit.kind  = mlpe_pkg::KIND_PASS;
                s_emit.data  = s_cell_n[IDX_W'(v_fill - CNT_W'(1))];
                s_emit.last  = v_flush && (v_drain == CNT_W'(1));
                n_drain      = v_drain - CNT_W'(1);
                n_fill       = v_fill - CNT_W'(1);
            end
        end
        if ((n_drain == '0) && n_clr) begin
            n_fill = '0;
            n_clr  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_drain    <= '0;
            r_clr      <= 1'b0;
            r_flush    <= 1'b0;
            r_sp.valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_drain <= n_drain;
            r_clr   <= n_clr;
            r_flush <= n_flush;
            r_sp    <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_free) begin
            r_out_valid <= s_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_free && s_emit.valid) begin
            r_out_kind <= s_emit.kind;
            r_out_byte <= s_emit.data;
            r_out_last <= s_emit.last;
        end
    end

    `MLPE_ASSERT_IMP(a_drain_fill, i_clk, i_rst_n, 1'b1, r_drain <= r_fill)
    `MLPE_ASSERT_IMP(a_sp_excl, i_clk, i_rst_n, r_sp.valid, r_drain == '0)
    `MLPE_ASSERT_IMP(a_last_kind, i_clk, i_rst_n, o_out.valid && o_out.last, s_byte_kind)
    `MLPE_ASSERT_NXT(a_hit_leaves, i_clk, i_rst_n, s_shift && s_hit, !s_search)

endmodule

// ===== tb/tb_marker_length_prefixed_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_marker_length_prefixed_extractor
// Drives byte and flush requests into the extractor under several marker
// settings, with directed framing cases first and random well-formed and
// broken frames after. A scoreboard predicts every result of every request
// and checks the result channel in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_marker_length_prefixed_extractor;

    localparam int          PHASE_ITEMS = 14;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        mlpe_pkg::t_kind kind;
        logic [7:0]      data;
        logic            last;
    } t_due_result;

    class stream_scoreboard;
        logic [mlpe_pkg::MARKER_W-1:0] marker = mlpe_pkg::MARKER_RESET;
        logic [mlpe_pkg::MLEN_W-1:0]   mlen   = mlpe_pkg::MLEN_RESET;
        logic [7:0]          win [mlpe_pkg::MARKER_MAX_DEF] = '{default: '0};
        int unsigned         fill = 0;
        mlpe_pkg::t_phase    stage = mlpe_pkg::PH_SEARCH;
        logic [mlpe_pkg::LEN_W-1:0] len_acc = '0;
        logic [2:0]          digits = '0;
        logic [mlpe_pkg::LEN_W-1:0] remaining = '0;
        t_due_result         due_results[$];
        int                  errors = 0;

        function void write_reg(mlpe_pkg::t_cfg_idx idx,
                                logic [mlpe_pkg::CFG_DATA_W-1:0] value);
            if (idx == mlpe_pkg::CFG_MARKER_BYTES) marker = value;
            else mlen = value[mlpe_pkg::MLEN_W-1:0];
        endfunction

        function int unsigned marker_span();
            if (mlen == 0) return 1;
            if (mlen > mlpe_pkg::MARKER_MAX_DEF) return mlpe_pkg::MARKER_MAX_DEF;
            return mlen;
        endfunction

        function void push(mlpe_pkg::t_kind k, logic [7:0] b, logic l);
            t_due_result r;
            r.kind = k;
            r.data = b;
            r.last = l;
            due_results.push_back(r);
        endfunction

        function void clear_window();
            foreach (win[i]) win[i] = '0;
            fill = 0;
        endfunction

        // oldest k held bytes leave as passthrough
        function void release_oldest(int unsigned k);
            int unsigned i;
            for (i = 0; i < k; i++) push(mlpe_pkg::KIND_PASS, win[i], 1'b0);
            i = 0;
            while (i + k < fill) begin
                win[i] = win[i + k];
                i++;
            end
            while (i < mlpe_pkg::MARKER_MAX_DEF) begin
                win[i] = '0;
                i++;
            end
            fill -= k;
        endfunction

        function void search_window(logic [7:0] b);
            int unsigned span;
            int unsigned c;
            bit          hit;
            span = marker_span();
            if (fill >= mlpe_pkg::MARKER_MAX_DEF)
                release_oldest(fill - mlpe_pkg::MARKER_MAX_DEF + 1);
            win[fill] = b;
            fill++;
            c = fill;
            hit = (c >= span);
            if (hit) begin
                for (int i = 0; i < span; i++) begin
                    if (win[c - 1 - i] != marker[8*i +: 8]) hit = 1'b0;
                end
            end
            if (hit) begin
                release_oldest(c - span);
                clear_window();
                stage   = mlpe_pkg::PH_LENGTH;
                len_acc = '0;
                digits  = '0;
            end else if (c > span - 1) begin
                release_oldest(c - (span - 1));
            end
        endfunction

        function void note_request(logic mode, logic [7:0] b);
            int unsigned k;
            if (mode) begin
                if (stage == mlpe_pkg::PH_SEARCH && fill > 0) begin
                    k = fill;
                    for (int i = 0; i < k; i++)
                        push(mlpe_pkg::KIND_PASS, win[i], i + 1 == k);
                    clear_window();
                end
                return;
            end
            case (stage)
                mlpe_pkg::PH_SEARCH: search_window(b);
                mlpe_pkg::PH_LENGTH: begin
                    if (b == mlpe_pkg::CH_SPACE) begin
                        if (len_acc == 0) begin
                            push(mlpe_pkg::KIND_EMPTY, 8'h00, 1'b0);
                            stage = mlpe_pkg::PH_SEARCH;
                        end else begin
                            remaining = len_acc;
                            stage = mlpe_pkg::PH_PAYLOAD;
                        end
                        len_acc = '0;
                        digits  = '0;
                    end else if (b >= mlpe_pkg::CH_ZERO && b <= mlpe_pkg::CH_NINE &&
                                 digits < mlpe_pkg::MAX_LENGTH_DIGITS_DEF) begin
                        len_acc = mlpe_pkg::LEN_W'(len_acc * 10 + (b - mlpe_pkg::CH_ZERO));
                        digits++;
                    end else begin
                        push(mlpe_pkg::KIND_ERROR, 8'h00, 1'b0);
                        stage   = mlpe_pkg::PH_SEARCH;
                        len_acc = '0;
                        digits  = '0;
                    end
                end
                default: begin
                    if (remaining > 0) remaining--;
                    push(mlpe_pkg::KIND_PAYLOAD, b, remaining == 0);
                    if (remaining == 0) stage = mlpe_pkg::PH_SEARCH;
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] b, logic l);
            t_due_result e;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                         $time, kind, b, l);
                errors++;
                return;
            end
            e = due_results.pop_front();
            if ({e.kind, e.data, e.last} !== {kind, b, l}) begin
                $display({"%0t: mismatch expected kind=%0d byte=%02h last=%0b,",
                          " got kind=%0d byte=%02h last=%0b"},
                         $time, e.kind, e.data, e.last, kind, b, l);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    mlpe_pkg::t_cfg_idx              cfg_idx;
    logic [mlpe_pkg::CFG_DATA_W-1:0] cfg_data;

    mlpe_in_if  in_ch ();
    mlpe_out_if out_ch ();

    stream_scoreboard sb = new;
    int unsigned      sent_items = 0;
    bit               idle_en = 1'b1;
    bit               hold_req = 1'b0;
    int unsigned      cycles = 0;

    marker_length_prefixed_extractor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[marker_length_prefixed_extractor] ERROR");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin
        int unsigned stall;
        int unsigned gap;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.kind, out_ch.out_byte, out_ch.last);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    stall = gap - 1;
                end
            end
        end
    end

    task automatic offer(input logic mode, input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.data_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(mode, b);
        sent_items++;
    endtask

    task automatic send_data(input logic [7:0] b);
        offer(1'b0, b);
    endtask

    task automatic send_flush();
        offer(1'b1, 8'($urandom));
    endtask

    // park the sender until every predicted result is out
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [mlpe_pkg::MARKER_W-1:0] mk,
                                input logic [mlpe_pkg::MLEN_W-1:0] ln);
        cfg_we   <= 1'b1;
        cfg_idx  <= mlpe_pkg::CFG_MARKER_BYTES;
        cfg_data <= mk;
        @(posedge i_clk);
        sb.write_reg(mlpe_pkg::CFG_MARKER_BYTES, mk);
        cfg_idx  <= mlpe_pkg::CFG_MARKER_LENGTH;
        cfg_data <= mlpe_pkg::CFG_DATA_W'(ln);
        @(posedge i_clk);
        sb.write_reg(mlpe_pkg::CFG_MARKER_LENGTH, mlpe_pkg::CFG_DATA_W'(ln));
        cfg_we   <= 1'b0;
    endtask

    // first n bytes of the current marker, oldest first
    task automatic send_marker(input int unsigned n);
        int          top;
        logic [63:0] mk;
        top = sb.marker_span();
        mk  = sb.marker;
        for (int i = 0; i < n; i++) send_data(mk[8*(top - 1 - i) +: 8]);
    endtask

    task automatic send_digits(input int unsigned value, input int unsigned ndig);
        int unsigned div;
        for (int k = ndig - 1; k >= 0; k--) begin
            div = 1;
            repeat (k) div *= 10;
            send_data(mlpe_pkg::CH_ZERO + 8'((value / div) % 10));
        end
    endtask

    task automatic send_frame(input int unsigned plen);
        int unsigned need;
        need = (plen >= 1000) ? 4 : (plen >= 100) ? 3 : (plen >= 10) ? 2 : 1;
        send_marker(sb.marker_span());
        send_digits(plen, $urandom_range(need, mlpe_pkg::MAX_LENGTH_DIGITS_DEF));
        send_data(mlpe_pkg::CH_SPACE);
        repeat (plen) begin
            if ($urandom_range(0, 19) == 0) send_flush();
            send_data(8'($urandom));
        end
    endtask

    task automatic send_broken();
        logic [7:0] bad;
        case ($urandom_range(0, 4))
            0: begin
                send_marker(sb.marker_span());
                send_data(mlpe_pkg::CH_SPACE);
            end
            1: begin
                send_marker(sb.marker_span());
                send_digits(0, $urandom_range(1, mlpe_pkg::MAX_LENGTH_DIGITS_DEF));
                send_data(mlpe_pkg::CH_SPACE);
            end
            2: begin
                send_marker(sb.marker_span());
                send_digits($urandom_range(0, 999), $urandom_range(0, 3));
                do bad = 8'($urandom);
                while ((bad >= mlpe_pkg::CH_ZERO && bad <= mlpe_pkg::CH_NINE) ||
                       bad == mlpe_pkg::CH_SPACE);
                send_data(bad);
            end
            3: begin
                send_marker(sb.marker_span());
                send_digits($urandom_range(0, 99999), mlpe_pkg::MAX_LENGTH_DIGITS_DEF + 1);
            end
            default: begin
                send_marker(sb.marker_span() - 1);
                send_data(8'($urandom));
            end
        endcase
    endtask

    function automatic int unsigned pick_payload_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 12);
        if (r < 95) return $urandom_range(13, 40);
        return $urandom_range(41, 99);
    endfunction

    task automatic run_phase(input logic [mlpe_pkg::MARKER_W-1:0] mk,
                             input logic [mlpe_pkg::MLEN_W-1:0] ln,
                             input bit quiet, input bit with_hold,
                             input int unsigned long_frame);
        int unsigned start;
        int unsigned pick;
        settle();
        apply_config(mk, ln);
        idle_en = !quiet;
        start = sent_items;
        if (with_hold) begin
            repeat (4) send_data(8'($urandom));
            hold_req = 1'b1;
        end
        while (sent_items - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) send_frame(pick_payload_len());
            else if (pick < 70) send_broken();
            else if (pick < 90) repeat ($urandom_range(1, 6)) send_data(8'($urandom));
            else send_flush();
        end
        if (long_frame > 0) send_frame(long_frame);
        // leave bytes held in the window for the next marker length
        repeat ($urandom_range(3, 7)) send_data(8'($urandom));
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= mlpe_pkg::CFG_MARKER_BYTES;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= 1'b0;
        in_ch.data_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases on a two-byte marker 7e 24
        apply_config(64'h7E24, 4'd2);
        send_flush();                   // empty window: nothing
        send_data(8'h00);
        send_data(8'hFF);
        send_flush();                   // releases ff as last
        send_marker(2);
        send_data(mlpe_pkg::CH_SPACE);  // space with no digits
        send_marker(2);
        send_data(mlpe_pkg::CH_ZERO);
        send_data(mlpe_pkg::CH_SPACE);  // zero length
        send_marker(2);
        send_flush();                   // flush while reading length: ignored
        send_data(mlpe_pkg::CH_ZERO + 8'd1);
        send_data(8'hFF);               // bad character
        send_marker(2);
        send_digits(99999, 5);          // one digit too many
        send_marker(2);
        send_data(mlpe_pkg::CH_ZERO + 8'd2);
        send_data(mlpe_pkg::CH_SPACE);
        send_data(8'hFF);
        send_flush();                   // flush during payload: ignored
        send_data(8'h00);

        run_phase(mlpe_pkg::MARKER_RESET, mlpe_pkg::MLEN_RESET, 1'b0, 1'b1, 0);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, $urandom_range(100, 120));
        run_phase(64'h0, 4'd1, 1'b1, 1'b0, 0);
        run_phase({$urandom, $urandom}, 4'd0, 1'b0, 1'b0, 0);
        run_phase({$urandom, $urandom}, 4'd15, 1'b1, 1'b0, 0);
        repeat (4) begin
            run_phase({$urandom, $urandom}, 4'($urandom_range(2, 7)),
                      $urandom_range(0, 3) == 0, 1'b0, 0);
        end
        settle();

        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("[marker_length_prefixed_extractor] OK");
        end else begin
            $display("[marker_length_prefixed_extractor] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/mlpe_pkg.sv
design/mlpe_in_if.sv
design/mlpe_out_if.sv
design/mlpe_cell.sv
design/mlpe_phase.sv
design/marker_length_prefixed_extractor.sv
tb/tb_marker_length_prefixed_extractor.sv
